### rtl/bezier_two_link_arm_ik_unit_macros.svh
// Assertion macros used by the checker of the arm solver
`ifndef BEZIER_TWO_LINK_ARM_IK_UNIT_MACROS_SVH
`define BEZIER_TWO_LINK_ARM_IK_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset
`define BT2IK_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define BT2IK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bt2ik_pkg.sv
// Shared types, constants and tables of the Bezier two-link arm solver
`default_nettype none
package bt2ik_pkg;

   // link lengths in mm
   localparam int UPPER_LINK_MM_DEF = 440;
   localparam int LOWER_LINK_MM_DEF = 460;
   localparam int Q4_SCALE          = 16;

   // widths
   localparam int COORD_W   = 15;
   localparam int WRIST_W   = 16;
   localparam int PARAM_W   = 17;
   localparam int CSR_IDX_W = 4;
   localparam int NUM_W     = 34;
   localparam int R2_W      = 33;
   localparam int SQRT_IN_W = 64;
   localparam int ROOT_W    = 32;
   localparam int CORD_W    = 44;
   localparam int ANG_W     = 26;
   localparam int SHOULDER_W = 16;
   localparam int ELBOW_W   = 14;

   localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X = 4'd0,
      CSR_START_Y = 4'd1,
      CSR_CTRL1_X = 4'd2,
      CSR_CTRL1_Y = 4'd3,
      CSR_CTRL2_X = 4'd4,
      CSR_CTRL2_Y = 4'd5,
      CSR_END_X   = 4'd6,
      CSR_END_Y   = 4'd7
   } csr_index_type;

   localparam logic signed [COORD_W-1:0] START_X_RST = 15'sd4800;
   localparam logic signed [COORD_W-1:0] START_Y_RST = 15'sd1600;

   // four control points of the curve
   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] ctrl1_x;
      logic signed [COORD_W-1:0] ctrl1_y;
      logic signed [COORD_W-1:0] ctrl2_x;
      logic signed [COORD_W-1:0] ctrl2_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } bez_points_type;

   // one result word
   typedef struct packed {
      logic signed [WRIST_W-1:0]    wrist_x;
      logic signed [WRIST_W-1:0]    wrist_y;
      logic signed [SHOULDER_W-1:0] shoulder;
      logic [ELBOW_W-1:0]           elbow;
      logic                         reachable;
   } result_type;

   // pipeline depths
   localparam int BEZ_LAT      = 6;
   localparam int SQRT_LAT     = ROOT_W;
   localparam int NORM_STEPS   = 6;
   localparam int NORM_LOG     = 38;
   localparam int CORDIC_STEPS = 22;
   localparam int ATAN_LAT     = 1 + NORM_STEPS + 1 + CORDIC_STEPS;

   // angles in Q.16 degrees
   localparam logic signed [ANG_W-1:0] DEG90 = 26'sd5898240;
   localparam int ROUND_Q6  = 512;
   localparam int SHIFT_Q6  = 10;
   localparam int ELBOW_MAX = 11520;

   localparam logic [21:0] ARC_TABLE [0:CORDIC_STEPS-1] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
      22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2
   };

endpackage
`default_nettype wire

### rtl/bt2ik_delay.sv
// Valid-tagged shift line that carries side data alongside a datapath
`default_nettype none
module bt2ik_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             valid_arg,
   input  logic [WIDTH-1:0] data_arg,
   output logic             valid_out,
   output logic [WIDTH-1:0] data_out
);

   logic             valid_ff [0:DEPTH-1];
   logic [WIDTH-1:0] data_ff  [0:DEPTH-1];

   // valid bits: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= valid_arg;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // data shifts with the valid bits
   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= data_arg;
         for (int i = 1; i < DEPTH; i++) data_ff[i] <= data_ff[i-1];
      end
   end

   assign valid_out = valid_ff[DEPTH-1];
   assign data_out  = data_ff[DEPTH-1];

endmodule
`default_nettype wire

### rtl/bt2ik_bezier.sv
// Six-stage cubic Bezier evaluator: weights, products, rounded sums
`default_nettype none
module bt2ik_bezier (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic [bt2ik_pkg::PARAM_W-1:0]         t_arg,
   input  bt2ik_pkg::bez_points_type             pts,
   output logic signed [bt2ik_pkg::WRIST_W-1:0]  wx,
   output logic signed [bt2ik_pkg::WRIST_W-1:0]  wy
);

   localparam int PW = bt2ik_pkg::PARAM_W;
   localparam int CW = bt2ik_pkg::COORD_W;
   localparam logic signed [65:0] ROUND_BEZ = 66'sd1 <<< 47;

   logic signed [CW-1:0] pt_x [0:3];
   logic signed [CW-1:0] pt_y [0:3];

   logic [PW-1:0] t_in, t_ff, u_ff, t2_ff, u2_ff;
   logic [32:0]   uu_ff, tt_ff;
   logic [49:0]   m0, m1, m2, m3;
   logic [48:0]   w_in [0:3];
   logic [48:0]   w_ff [0:3];
   logic signed [63:0] px_ff [0:3];
   logic signed [63:0] py_ff [0:3];
   logic signed [64:0] sax_ff, sbx_ff, say_ff, sby_ff;
   logic signed [65:0] sumx, sumy;
   logic signed [bt2ik_pkg::WRIST_W-1:0] wx_ff, wy_ff;

   assign pt_x[0] = pts.start_x;
   assign pt_x[1] = pts.ctrl1_x;
   assign pt_x[2] = pts.ctrl2_x;
   assign pt_x[3] = pts.end_x;
   assign pt_y[0] = pts.start_y;
   assign pt_y[1] = pts.ctrl1_y;
   assign pt_y[2] = pts.ctrl2_y;
   assign pt_y[3] = pts.end_y;

   // parameter saturates at one
   assign t_in = (t_arg > bt2ik_pkg::ONE_Q16) ? bt2ik_pkg::ONE_Q16 : t_arg;

   // weights u^3, 3u^2t, 3ut^2, t^3 in Q1.48
   assign m0 = 50'(uu_ff * u2_ff);
   assign m1 = 50'(uu_ff * t2_ff);
   assign m2 = 50'(tt_ff * u2_ff);
   assign m3 = 50'(tt_ff * t2_ff);
   assign w_in[0] = m0[48:0];
   assign w_in[1] = 49'(m1 + {m1[48:0], 1'b0});
   assign w_in[2] = 49'(m2 + {m2[48:0], 1'b0});
   assign w_in[3] = m3[48:0];

   // final sum with round to nearest Q11.4
   assign sumx = 66'(sax_ff) + 66'(sbx_ff) + ROUND_BEZ;
   assign sumy = 66'(say_ff) + 66'(sby_ff) + ROUND_BEZ;

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff   <= t_in;
         u_ff   <= PW'(bt2ik_pkg::ONE_Q16 - t_in);
         uu_ff  <= 33'(u_ff * u_ff);
         tt_ff  <= 33'(t_ff * t_ff);
         t2_ff  <= t_ff;
         u2_ff  <= u_ff;
         for (int j = 0; j < 4; j++) begin
            w_ff[j]  <= w_in[j];
            px_ff[j] <= 64'($signed({1'b0, w_ff[j]}) * pt_x[j]);
            py_ff[j] <= 64'($signed({1'b0, w_ff[j]}) * pt_y[j]);
         end
         sax_ff <= 65'(px_ff[0]) + 65'(px_ff[1]);
         sbx_ff <= 65'(px_ff[2]) + 65'(px_ff[3]);
         say_ff <= 65'(py_ff[0]) + 65'(py_ff[1]);
         sby_ff <= 65'(py_ff[2]) + 65'(py_ff[3]);
         wx_ff  <= sumx[63:48];
         wy_ff  <= sumy[63:48];
      end
   end

   assign wx = wx_ff;
   assign wy = wy_ff;

endmodule
`default_nettype wire

### rtl/bt2ik_isqrt.sv
// Integer square root, one result bit per pipeline stage
`default_nettype none
module bt2ik_isqrt (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [bt2ik_pkg::SQRT_IN_W-1:0]     rad_arg,
   output logic [bt2ik_pkg::ROOT_W-1:0]        root
);

   localparam int VW = bt2ik_pkg::SQRT_IN_W;
   localparam int NS = bt2ik_pkg::SQRT_LAT;

   logic [VW-1:0] v_ff [0:NS-1];
   logic [VW-1:0] r_ff [0:NS-1];

   for (genvar k = 0; k < NS; k++) begin : g_step
      localparam logic [VW-1:0] BITK = VW'(1) << (VW - 2 - 2 * k);
      logic [VW-1:0] v_prev, r_prev, v_in, r_in;
      logic [VW:0]   trial;

      if (k == 0) begin : g_first
         assign v_prev = rad_arg;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[k-1];
         assign r_prev = r_ff[k-1];
      end

      // try the next bit
      assign trial = {1'b0, r_prev} + {1'b0, BITK};
      always_comb begin
         if ({1'b0, v_prev} >= trial) begin
            v_in = VW'({1'b0, v_prev} - trial);
            r_in = (r_prev >> 1) + BITK;
         end else begin
            v_in = v_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            v_ff[k] <= v_in;
            r_ff[k] <= r_in;
         end
      end
   end

   assign root = r_ff[NS-1][bt2ik_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

### rtl/bt2ik_atan.sv
// Pipelined atan2: quadrant fold, normalising shifts, 22 CORDIC stages
`default_nettype none
module bt2ik_atan (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [bt2ik_pkg::CORD_W-1:0]  y_arg,
   input  logic signed [bt2ik_pkg::CORD_W-1:0]  x_arg,
   output logic signed [bt2ik_pkg::ANG_W-1:0]   angle
);

   localparam int CW = bt2ik_pkg::CORD_W;
   localparam int AW = bt2ik_pkg::ANG_W;
   localparam int NL = bt2ik_pkg::ATAN_LAT;
   localparam int NN = bt2ik_pkg::NORM_STEPS;

   logic signed [CW-1:0] sx_ff [0:NL-1];
   logic signed [CW-1:0] sy_ff [0:NL-1];
   logic signed [AW-1:0] sz_ff [0:NL-1];
   logic                 zero_ff [0:NL-1];

   logic signed [CW-1:0] x0_in, y0_in;
   logic signed [AW-1:0] z0_in;

   function automatic logic [CW-1:0] max_mag(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
      logic [CW-1:0] ma, mb;
      ma = a[CW-1] ? CW'(-a) : CW'(a);
      mb = b[CW-1] ? CW'(-b) : CW'(b);
      return (ma > mb) ? ma : mb;
   endfunction

   // fold the left half plane by a quarter turn
   always_comb begin
      x0_in = x_arg;
      y0_in = y_arg;
      z0_in = '0;
      if (x_arg < 0) begin
         if (y_arg >= 0) begin
            x0_in = y_arg;
            y0_in = -x_arg;
            z0_in = bt2ik_pkg::DEG90;
         end else begin
            x0_in = -y_arg;
            y0_in = x_arg;
            z0_in = -bt2ik_pkg::DEG90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0]   <= x0_in;
         sy_ff[0]   <= y0_in;
         sz_ff[0]   <= z0_in;
         zero_ff[0] <= (x_arg == 0) && (y_arg == 0);
      end
   end

   for (genvar k = 1; k < NL; k++) begin : g_stage
      logic signed [CW-1:0] x_in, y_in;
      logic signed [AW-1:0] z_in;

      if (k <= NN + 1) begin : g_norm
         // binary search for the shift that lifts the larger magnitude to 2^38
         localparam int SH = (k <= NN) ? (1 << (NN - k)) : 1;
         localparam int LG = (k <= NN) ? (bt2ik_pkg::NORM_LOG - SH) : bt2ik_pkg::NORM_LOG;
         localparam logic [CW-1:0] LIM = CW'(1) << LG;
         logic [CW-1:0] m;
         assign m    = max_mag(sx_ff[k-1], sy_ff[k-1]);
         assign x_in = (m < LIM) ? (sx_ff[k-1] <<< SH) : sx_ff[k-1];
         assign y_in = (m < LIM) ? (sy_ff[k-1] <<< SH) : sy_ff[k-1];
         assign z_in = sz_ff[k-1];
      end else begin : g_rot
         // one vectoring micro-rotation
         localparam int I = k - NN - 2;
         localparam logic signed [AW-1:0] ARC = $signed(AW'(bt2ik_pkg::ARC_TABLE[I]));
         always_comb begin
            if (sy_ff[k-1] > 0) begin
               x_in = sx_ff[k-1] + (sy_ff[k-1] >>> I);
               y_in = sy_ff[k-1] - (sx_ff[k-1] >>> I);
               z_in = sz_ff[k-1] + ARC;
            end else begin
               x_in = sx_ff[k-1] - (sy_ff[k-1] >>> I);
               y_in = sy_ff[k-1] + (sx_ff[k-1] >>> I);
               z_in = sz_ff[k-1] - ARC;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sx_ff[k]   <= x_in;
            sy_ff[k]   <= y_in;
            sz_ff[k]   <= z_in;
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   // origin gives zero angle
   assign angle = zero_ff[NL-1] ? '0 : sz_ff[NL-1];

endmodule
`default_nettype wire

### rtl/bezier_two_link_arm_ik_unit.sv
// Top level of the Bezier trajectory point and two-link arm solver
// Takes one curve parameter word per cycle unless stalled and returns the
// curve point and the shoulder and elbow angles of a planar two-link arm
// reaching it. The path is fully pipelined: 6 stages of Bezier evaluation,
// 4 of radius and reach test, 32 of square root (one root bit per stage),
// 30 of three parallel atan2 units (fold, 7 normalising shifts, 22 CORDIC
// rotations) and one output register. A one-word skid buffer behind the
// output lets the input flow in the cycle the result side stalls; req_stall
// is then raised until that word drains. The user must write the control
// points via the csr port (always ready) only while idle; it is not enforced.
`default_nettype none
module bezier_two_link_arm_ik_unit #(
   parameter int UPPER_LINK_MM = bt2ik_pkg::UPPER_LINK_MM_DEF,
   parameter int LOWER_LINK_MM = bt2ik_pkg::LOWER_LINK_MM_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // input word
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [bt2ik_pkg::PARAM_W-1:0]            req_curve_param,
   input  logic                                     req_elbow_backward,
   // result word
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [bt2ik_pkg::WRIST_W-1:0]     rsp_wrist_x,
   output logic signed [bt2ik_pkg::WRIST_W-1:0]     rsp_wrist_y,
   output logic signed [bt2ik_pkg::SHOULDER_W-1:0]  rsp_shoulder_angle,
   output logic [bt2ik_pkg::ELBOW_W-1:0]            rsp_elbow_angle,
   output logic                                     rsp_reachable,
   // register writes
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [bt2ik_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic signed [bt2ik_pkg::COORD_W-1:0]     csr_data
);

   localparam int WW = bt2ik_pkg::WRIST_W;
   localparam int NW = bt2ik_pkg::NUM_W;
   localparam int RW = bt2ik_pkg::R2_W;
   localparam int VW = bt2ik_pkg::SQRT_IN_W;
   localparam int CW = bt2ik_pkg::CORD_W;
   localparam int AW = bt2ik_pkg::ANG_W;

   // link geometry in Q.4
   localparam longint LA = longint'(UPPER_LINK_MM) * bt2ik_pkg::Q4_SCALE;
   localparam longint LB = longint'(LOWER_LINK_MM) * bt2ik_pkg::Q4_SCALE;
   localparam logic [RW-1:0] REACH_HI = RW'((LA + LB) * (LA + LB));
   localparam logic [RW-1:0] REACH_LO = RW'((LA - LB) * (LA - LB));
   localparam logic signed [NW-1:0] SUM_SQ  = NW'(LA * LA + LB * LB);
   localparam logic signed [NW-1:0] DIFF_SQ = NW'(LA * LA - LB * LB);
   localparam logic [VW-1:0] DEN_SQ = VW'((2 * LA * LB) * (2 * LA * LB));

   localparam int P1_W = NW + NW + WW + WW + 2;
   localparam int P2_W = WW + WW + 2;

   logic adv;
   bt2ik_pkg::bez_points_type pts_ff;

   // control point registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff.start_x <= bt2ik_pkg::START_X_RST;
         pts_ff.start_y <= bt2ik_pkg::START_Y_RST;
         pts_ff.ctrl1_x <= '0;
         pts_ff.ctrl1_y <= '0;
         pts_ff.ctrl2_x <= '0;
         pts_ff.ctrl2_y <= '0;
         pts_ff.end_x   <= '0;
         pts_ff.end_y   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bt2ik_pkg::CSR_START_X: pts_ff.start_x <= csr_data;
            bt2ik_pkg::CSR_START_Y: pts_ff.start_y <= csr_data;
            bt2ik_pkg::CSR_CTRL1_X: pts_ff.ctrl1_x <= csr_data;
            bt2ik_pkg::CSR_CTRL1_Y: pts_ff.ctrl1_y <= csr_data;
            bt2ik_pkg::CSR_CTRL2_X: pts_ff.ctrl2_x <= csr_data;
            bt2ik_pkg::CSR_CTRL2_Y: pts_ff.ctrl2_y <= csr_data;
            bt2ik_pkg::CSR_END_X:   pts_ff.end_x   <= csr_data;
            bt2ik_pkg::CSR_END_Y:   pts_ff.end_y   <= csr_data;
            default: ;
         endcase
      end
   end

   // curve point
   logic signed [WW-1:0] bz_wx, bz_wy;
   logic                 bz_valid, bz_back;

   bt2ik_bezier u_bezier (
      .clock (clock),
      .adv   (adv),
      .t_arg (req_curve_param),
      .pts   (pts_ff),
      .wx    (bz_wx),
      .wy    (bz_wy)
   );

   bt2ik_delay #(.WIDTH(1), .DEPTH(bt2ik_pkg::BEZ_LAT)) u_dly_bez (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_arg (req_valid),
      .data_arg  (req_elbow_backward),
      .valid_out (bz_valid),
      .data_out  (bz_back)
   );

   // radius, reach test, law-of-cosines terms, radicand
   logic                 v7_ff, v8_ff, v9_ff, v10_ff;
   logic signed [WW-1:0] wx7_ff, wy7_ff, wx8_ff, wy8_ff, wx9_ff, wy9_ff, wx10_ff, wy10_ff;
   logic                 bk7_ff, bk8_ff, bk9_ff, bk10_ff;
   logic                 ok8_ff, ok9_ff, ok10_ff;
   logic [RW-1:0]        r2_ff;
   logic signed [NW-1:0] nb8_ff, ng8_ff, nb9_ff, ng9_ff, nb10_ff, ng10_ff;
   logic [VW-1:0]        nbsq_ff, rad_ff;
   logic signed [31:0]   sqx, sqy;
   logic [NW-1:0]        nb_abs;

   assign sqx    = bz_wx * bz_wx;
   assign sqy    = bz_wy * bz_wy;
   assign nb_abs = nb8_ff[NW-1] ? NW'(-nb8_ff) : NW'(nb8_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (adv) begin
         v7_ff  <= bz_valid;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wx7_ff  <= bz_wx;
         wy7_ff  <= bz_wy;
         bk7_ff  <= bz_back;
         r2_ff   <= RW'($unsigned(sqx)) + RW'($unsigned(sqy));
         wx8_ff  <= wx7_ff;
         wy8_ff  <= wy7_ff;
         bk8_ff  <= bk7_ff;
         ok8_ff  <= (r2_ff <= REACH_HI) && (r2_ff >= REACH_LO);
         nb8_ff  <= SUM_SQ - $signed({1'b0, r2_ff});
         ng8_ff  <= $signed({1'b0, r2_ff}) + DIFF_SQ;
         wx9_ff  <= wx8_ff;
         wy9_ff  <= wy8_ff;
         bk9_ff  <= bk8_ff;
         ok9_ff  <= ok8_ff;
         nb9_ff  <= nb8_ff;
         ng9_ff  <= ng8_ff;
         nbsq_ff <= VW'(nb_abs[31:0] * nb_abs[31:0]);
         wx10_ff <= wx9_ff;
         wy10_ff <= wy9_ff;
         bk10_ff <= bk9_ff;
         ok10_ff <= ok9_ff;
         nb10_ff <= nb9_ff;
         ng10_ff <= ng9_ff;
         rad_ff  <= (DEN_SQ >= nbsq_ff) ? (DEN_SQ - nbsq_ff) : '0;
      end
   end

   // square root with side data alongside
   logic [bt2ik_pkg::ROOT_W-1:0] root;
   logic                         sq_valid;
   logic [P1_W-1:0]              sq_data;
   logic signed [NW-1:0]         sq_nb, sq_ng;
   logic signed [WW-1:0]         sq_wx, sq_wy;
   logic                         sq_bk, sq_ok;

   bt2ik_isqrt u_isqrt (
      .clock   (clock),
      .adv     (adv),
      .rad_arg (rad_ff),
      .root    (root)
   );

   bt2ik_delay #(.WIDTH(P1_W), .DEPTH(bt2ik_pkg::SQRT_LAT)) u_dly_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_arg (v10_ff),
      .data_arg  ({nb10_ff, ng10_ff, wx10_ff, wy10_ff, bk10_ff, ok10_ff}),
      .valid_out (sq_valid),
      .data_out  (sq_data)
   );

   assign {sq_nb, sq_ng, sq_wx, sq_wy, sq_bk, sq_ok} = sq_data;

   // three angles in parallel
   logic signed [CW-1:0] root_ext;
   logic signed [AW-1:0] beta, gamma, theta;

   assign root_ext = $signed({{(CW - bt2ik_pkg::ROOT_W){1'b0}}, root});

   bt2ik_atan u_atan_elbow (
      .clock (clock),
      .adv   (adv),
      .y_arg (root_ext),
      .x_arg (CW'(sq_nb)),
      .angle (beta)
   );

   bt2ik_atan u_atan_gamma (
      .clock (clock),
      .adv   (adv),
      .y_arg (root_ext),
      .x_arg (CW'(sq_ng)),
      .angle (gamma)
   );

   bt2ik_atan u_atan_theta (
      .clock (clock),
      .adv   (adv),
      .y_arg (CW'(sq_wy)),
      .x_arg (CW'(sq_wx)),
      .angle (theta)
   );

   logic            fin_valid;
   logic [P2_W-1:0] fin_data;
   logic signed [WW-1:0] fin_wx, fin_wy;
   logic                 fin_bk, fin_ok;

   bt2ik_delay #(.WIDTH(P2_W), .DEPTH(bt2ik_pkg::ATAN_LAT)) u_dly_atan (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_arg (sq_valid),
      .data_arg  ({sq_wx, sq_wy, sq_bk, sq_ok}),
      .valid_out (fin_valid),
      .data_out  (fin_data)
   );

   assign {fin_wx, fin_wy, fin_bk, fin_ok} = fin_data;

   // shoulder sum, rounding to Q.6, elbow limit
   logic signed [AW:0]   sh_sum, sh_rnd;
   logic signed [AW-1:0] el_rnd;
   bt2ik_pkg::result_type res_in;

   assign sh_sum = fin_bk ? ((AW + 1)'(theta) - (AW + 1)'(gamma))
                          : ((AW + 1)'(theta) + (AW + 1)'(gamma));
   assign sh_rnd = (sh_sum + (AW + 1)'(bt2ik_pkg::ROUND_Q6)) >>> bt2ik_pkg::SHIFT_Q6;
   assign el_rnd = (beta + AW'(bt2ik_pkg::ROUND_Q6)) >>> bt2ik_pkg::SHIFT_Q6;

   always_comb begin
      res_in.wrist_x   = fin_wx;
      res_in.wrist_y   = fin_wy;
      res_in.reachable = fin_ok;
      res_in.shoulder  = '0;
      res_in.elbow     = '0;
      if (fin_ok) begin
         res_in.shoulder = sh_rnd[bt2ik_pkg::SHOULDER_W-1:0];
         if (el_rnd < 0) begin
            res_in.elbow = '0;
         end else if (el_rnd > AW'(bt2ik_pkg::ELBOW_MAX)) begin
            res_in.elbow = bt2ik_pkg::ELBOW_W'(bt2ik_pkg::ELBOW_MAX);
         end else begin
            res_in.elbow = el_rnd[bt2ik_pkg::ELBOW_W-1:0];
         end
      end
   end

   // output register and skid word
   logic                  out_valid_ff, skid_valid_ff, out_free;
   bt2ik_pkg::result_type out_ff, skid_ff;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_valid_ff <= fin_valid;
      end else if (fin_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) out_ff <= skid_ff;
      end else if (out_free) begin
         out_ff <= res_in;
      end else if (fin_valid) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_wrist_x        = out_ff.wrist_x;
   assign rsp_wrist_y        = out_ff.wrist_y;
   assign rsp_shoulder_angle = out_ff.shoulder;
   assign rsp_elbow_angle    = out_ff.elbow;
   assign rsp_reachable      = out_ff.reachable;

endmodule
`default_nettype wire

### rtl/bt2ik_checker.sv
// Port-level checker for the arm solver, bound to the top level
`default_nettype none
`include "bezier_two_link_arm_ik_unit_macros.svh"
module bt2ik_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_stall,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic signed [bt2ik_pkg::WRIST_W-1:0]     rsp_wrist_x,
   input logic signed [bt2ik_pkg::WRIST_W-1:0]     rsp_wrist_y,
   input logic signed [bt2ik_pkg::SHOULDER_W-1:0]  rsp_shoulder_angle,
   input logic [bt2ik_pkg::ELBOW_W-1:0]            rsp_elbow_angle,
   input logic                                     rsp_reachable
);

   // a stalled result word holds
   `BT2IK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_wrist_x) && $stable(rsp_wrist_y) && $stable(rsp_shoulder_angle) && $stable(rsp_elbow_angle) && $stable(rsp_reachable), "stalled result word changed")

   // unreachable targets carry zero angles
   `BT2IK_ASSERT_IMPL(a_unreach_zero, clock, reset, rsp_valid && !rsp_reachable, rsp_shoulder_angle == 0 && rsp_elbow_angle == 0, "unreachable word with nonzero angle")

   // elbow stays within half a turn
   `BT2IK_ASSERT_IMPL(a_elbow_range, clock, reset, rsp_valid, rsp_elbow_angle <= bt2ik_pkg::ELBOW_W'(bt2ik_pkg::ELBOW_MAX), "elbow angle beyond 180 degrees")

   // input stalls only after a stalled result
   `BT2IK_ASSERT_IMPL(a_stall_cause, clock, reset, $rose(req_stall), $past(rsp_valid && rsp_stall), "input stalled without output back-pressure")

endmodule

bind bezier_two_link_arm_ik_unit bt2ik_checker u_bt2ik_checker (.*);
`default_nettype wire
